### rtl/core/clcd_pkg.sv
// Shared types, constants and control store for the character LCD write sequencer.
package clcd_pkg;

  typedef enum logic [2:0] {
    OP_CMD     = 3'd0,
    OP_DATA    = 3'd1,
    OP_PUTXY   = 3'd2,
    OP_CLRLINE = 3'd3,
    OP_INIT    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_LINE0   = 3'd0,
    REG_LINE1   = 3'd1,
    REG_LINE2   = 3'd2,
    REG_LINE3   = 3'd3,
    REG_DISP_ON = 3'd4,
    REG_CUR_OFF = 3'd5,
    REG_HOME    = 3'd6,
    REG_CLEAR   = 3'd7
  } reg_idx_e;

  localparam int NumRegs = 8;
  localparam logic [7:0] CfgReset [NumRegs] = '{
    8'h80, 8'hC0, 8'h94, 8'hD4, 8'h0C, 8'h0C, 8'h02, 8'h01
  };

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam int         MaxSpaces = 19;

  localparam logic [14:0] ByteWait   = 15'd45;
  localparam logic [14:0] SlowWait   = 15'd2000;
  localparam logic [14:0] NibWait    = 15'd2000;
  localparam logic [14:0] LongWait   = 15'd20000;
  localparam logic [14:0] PowerWait  = 15'd20000;
  localparam logic [14:0] SecondWait = 15'd5000;

  // micro-instruction fields
  typedef enum logic {UK_NIB, UK_BYTE} ukind_e;
  typedef enum logic [1:0] {SRC_CONST, SRC_IN, SRC_REG, SRC_ADDR} usrc_e;
  typedef enum logic [1:0] {PRE_NONE, PRE_POWER, PRE_SECOND} upre_e;
  typedef enum logic [1:0] {CTL_NEXT, CTL_LOOP, CTL_END} uctl_e;

  typedef struct packed {
    ukind_e     kind;
    logic       rs;
    usrc_e      src;
    logic [7:0] konst;
    upre_e      pre;
    logic       xtra;
    uctl_e      ctl;
  } uword_t;

  localparam int UpcW = 5;

  localparam logic [UpcW-1:0] EntryCmd     = 5'd0;
  localparam logic [UpcW-1:0] EntryData    = 5'd1;
  localparam logic [UpcW-1:0] EntryPutXy   = 5'd2;
  localparam logic [UpcW-1:0] EntryClrLine = 5'd4;
  localparam logic [UpcW-1:0] EntryInit    = 5'd6;

  function automatic uword_t mk(ukind_e kind, logic rs, usrc_e src, logic [7:0] konst,
                                upre_e pre, logic xtra, uctl_e ctl);
    uword_t w;
    w.kind  = kind;
    w.rs    = rs;
    w.src   = src;
    w.konst = konst;
    w.pre   = pre;
    w.xtra  = xtra;
    w.ctl   = ctl;
    return w;
  endfunction

  function automatic uword_t cmd_c(logic [7:0] k);
    return mk(UK_BYTE, 1'b0, SRC_CONST, k, PRE_NONE, 1'b0, CTL_NEXT);
  endfunction

  function automatic uword_t glyph_c(logic [7:0] k);
    return mk(UK_BYTE, 1'b1, SRC_CONST, k, PRE_NONE, 1'b0, CTL_NEXT);
  endfunction

  function automatic uword_t cmd_r(reg_idx_e r, logic xtra, uctl_e ctl);
    return mk(UK_BYTE, 1'b0, SRC_REG, {5'd0, r}, PRE_NONE, xtra, ctl);
  endfunction

  // control store
  function automatic uword_t ucode(logic [UpcW-1:0] upc);
    uword_t w;
    case (upc)
      5'd0:    w = mk(UK_BYTE, 1'b0, SRC_IN, 8'h00, PRE_NONE, 1'b0, CTL_END);
      5'd1:    w = mk(UK_BYTE, 1'b1, SRC_IN, 8'h00, PRE_NONE, 1'b0, CTL_END);
      5'd2:    w = mk(UK_BYTE, 1'b0, SRC_ADDR, 8'h00, PRE_NONE, 1'b0, CTL_NEXT);
      5'd3:    w = mk(UK_BYTE, 1'b1, SRC_IN, 8'h00, PRE_NONE, 1'b0, CTL_END);
      5'd4:    w = mk(UK_BYTE, 1'b0, SRC_ADDR, 8'h00, PRE_NONE, 1'b0, CTL_NEXT);
      5'd5:    w = mk(UK_BYTE, 1'b1, SRC_CONST, SpaceChar, PRE_NONE, 1'b0, CTL_LOOP);
      5'd6:    w = mk(UK_NIB, 1'b0, SRC_CONST, 8'h03, PRE_POWER, 1'b0, CTL_NEXT);
      5'd7:    w = mk(UK_NIB, 1'b0, SRC_CONST, 8'h03, PRE_SECOND, 1'b0, CTL_NEXT);
      5'd8:    w = mk(UK_NIB, 1'b0, SRC_CONST, 8'h03, PRE_NONE, 1'b0, CTL_NEXT);
      5'd9:    w = mk(UK_NIB, 1'b0, SRC_CONST, 8'h02, PRE_NONE, 1'b0, CTL_NEXT);
      5'd10:   w = cmd_c(8'h20);
      5'd11:   w = cmd_c(8'h28);
      5'd12:   w = cmd_c(8'h14);
      5'd13:   w = cmd_c(8'h0F);
      5'd14:   w = cmd_r(REG_CLEAR, 1'b0, CTL_NEXT);
      5'd15:   w = cmd_c(8'h06);
      5'd16:   w = cmd_r(REG_DISP_ON, 1'b1, CTL_NEXT);
      5'd17:   w = cmd_r(REG_CUR_OFF, 1'b0, CTL_NEXT);
      5'd18:   w = cmd_c(8'h40);
      5'd19:   w = glyph_c(8'h08);
      5'd20:   w = glyph_c(8'h0C);
      5'd21:   w = glyph_c(8'h0E);
      5'd22:   w = glyph_c(8'h0F);
      5'd23:   w = glyph_c(8'h0E);
      5'd24:   w = glyph_c(8'h0C);
      5'd25:   w = glyph_c(8'h08);
      5'd26:   w = glyph_c(8'h00);
      5'd27:   w = cmd_r(REG_HOME, 1'b0, CTL_END);
      default: w = mk(UK_BYTE, 1'b0, SRC_IN, 8'h00, PRE_NONE, 1'b0, CTL_END);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/char_lcd_nibble_write_sequencer.sv
// Character LCD 4-bit write sequencer: request in, enable strobe records out.
//
// Slave stream takes one request, opcode on tuser (command, data, put char at
// column/row, clear line, init), byte, column and row on tdata.
// Master stream gives one record per LCD enable strobe:
// nibble, wait before and wait after the strobe, RS level on tuser and
// tlast on the final strobe of the request. A byte goes out as two records,
// high nibble first.
// The request is registered first; its first record is then loaded into the output register.
// Throughput: one record per cycle while the receiver takes them; a put-char
// or clear-line on a row above 3 spends a step with no record on the skipped
// address step. Init gives 40 records, clear line up to 40.
// A new request is taken as soon as the last record of the previous one sits
// in the output register. When the receiver stalls, the output record holds
// and the sequencer waits. Undefined opcodes are taken and give no records.
// Reset restores the register defaults (row bases 0x80/0xC0/0x94/0xD4, on and
// cursor-off 0x0C, home 0x02, clear 0x01) and empties the output.
// The user writes registers through cfg_we_i only while no request is in flight; the block does not enforce it.
module char_lcd_nibble_write_sequencer #(
  parameter int LINE_CHARS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // byte_value[7:0], column[11:8], row[14:12]
  input  logic [2:0]  s_tuser_i,   // opcode[2:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // nibble[3:0], pre_wait_us[18:4], post_wait_us[33:19]
  output logic        m_tuser_o,   // reg_select[0]
  output logic        m_tlast_o
);
  import clcd_pkg::*;

  localparam int NumSpaces = (LINE_CHARS > MaxSpaces) ? MaxSpaces : LINE_CHARS;
  localparam int CntW      = (NumSpaces > 1) ? $clog2(NumSpaces) : 1;
  localparam logic [CntW-1:0] LastSpace = CntW'(NumSpaces - 1);

  logic [7:0]      regs_q [NumRegs];
  logic            busy_q;
  logic [UpcW-1:0] upc_q;
  logic            half_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      byte_q;
  logic [3:0]      col_q;
  logic [2:0]      row_q;

  logic            out_valid_q;
  logic [3:0]      out_nib_q;
  logic [14:0]     out_pre_q;
  logic [14:0]     out_post_q;
  logic            out_rs_q;
  logic            out_last_q;

  uword_t          uw;
  logic [7:0]      cur_byte;
  logic            skip;
  logic            advance;
  logic            rec_load;
  logic            fin;
  logic            slow_cmd;
  logic [14:0]     pre_w;
  logic [14:0]     post_low;
  logic            in_acc;
  op_e             in_op;

  assign s_tready_o = !busy_q;
  assign in_acc     = s_tvalid_i && !busy_q;
  assign in_op      = op_e'(s_tuser_i);
  assign advance    = busy_q && (!out_valid_q || m_tready_i);
  assign rec_load   = advance && !skip;

  always_comb begin
    uw = ucode(upc_q);
    case (uw.src)
      SRC_CONST: cur_byte = uw.konst;
      SRC_IN:    cur_byte = byte_q;
      SRC_REG:   cur_byte = regs_q[uw.konst[2:0]];
      SRC_ADDR:  cur_byte = regs_q[{1'b0, row_q[1:0]}] + {4'd0, col_q};
      default:   cur_byte = byte_q;
    endcase
    skip     = (uw.src == SRC_ADDR) && row_q[2];
    slow_cmd = !uw.rs && (cur_byte == regs_q[REG_HOME] || cur_byte == regs_q[REG_CLEAR]);
    post_low = ByteWait + (slow_cmd ? SlowWait : 15'd0) + (uw.xtra ? LongWait : 15'd0);
    case (uw.pre)
      PRE_POWER:  pre_w = PowerWait;
      PRE_SECOND: pre_w = SecondWait;
      default:    pre_w = 15'd0;
    endcase
    fin = (uw.ctl == CTL_END) || (uw.ctl == CTL_LOOP && cnt_q == LastSpace);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= CfgReset[i];
      end
      busy_q      <= 1'b0;
      upc_q       <= '0;
      half_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        regs_q[cfg_idx_i] <= cfg_wdata_i;
      end

      if (out_valid_q && m_tready_i && !rec_load) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        byte_q <= s_tdata_i[7:0];
        col_q  <= (in_op == OP_CLRLINE) ? 4'd0 : s_tdata_i[11:8];
        row_q  <= s_tdata_i[14:12];
        half_q <= 1'b0;
        cnt_q  <= '0;
        busy_q <= in_op inside {OP_CMD, OP_DATA, OP_PUTXY, OP_CLRLINE, OP_INIT};
        case (in_op)
          OP_CMD:     upc_q <= EntryCmd;
          OP_DATA:    upc_q <= EntryData;
          OP_PUTXY:   upc_q <= EntryPutXy;
          OP_CLRLINE: upc_q <= EntryClrLine;
          OP_INIT:    upc_q <= EntryInit;
          default:    ;
        endcase
      end else if (advance) begin
        if (skip) begin
          upc_q <= upc_q + 1'b1;
        end else begin
          out_valid_q <= 1'b1;
          out_rs_q    <= uw.rs;
          if (uw.kind == UK_NIB) begin
            out_nib_q  <= uw.konst[3:0];
            out_pre_q  <= pre_w;
            out_post_q <= NibWait;
            out_last_q <= (uw.ctl == CTL_END);
            if (uw.ctl == CTL_END) begin
              busy_q <= 1'b0;
            end else begin
              upc_q <= upc_q + 1'b1;
            end
          end else if (!half_q) begin
            out_nib_q  <= cur_byte[7:4];
            out_pre_q  <= 15'd0;
            out_post_q <= 15'd0;
            out_last_q <= 1'b0;
            half_q     <= 1'b1;
          end else begin
            out_nib_q  <= cur_byte[3:0];
            out_pre_q  <= 15'd0;
            out_post_q <= post_low;
            out_last_q <= fin;
            half_q     <= 1'b0;
            if (fin) begin
              busy_q <= 1'b0;
            end else if (uw.ctl == CTL_LOOP) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              upc_q <= upc_q + 1'b1;
            end
          end
        end
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'd0, out_post_q, out_pre_q, out_nib_q};
  assign m_tuser_o  = out_rs_q;
  assign m_tlast_o  = out_last_q;

endmodule

### rtl/core/clcd_chk.sv
// Port-level checker for the character LCD write sequencer, bound to the top level.
module clcd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic [2:0]  s_tuser_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_o,
  input logic        m_tuser_o,
  input logic        m_tlast_o
);
  import clcd_pkg::*;

  // stalled record holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("output record changed while stalled");

  // a request with a defined opcode makes the sequencer busy in the cycle after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i == OP_CMD || s_tuser_i == OP_DATA ||
      s_tuser_i == OP_PUTXY || s_tuser_i == OP_CLRLINE || s_tuser_i == OP_INIT)
      |=> !s_tready_o)
    else $error("request taken while previous one still running");

  // only init nibbles carry a pre-wait
  a_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[18:4] != 15'd0 |-> !m_tuser_o && !m_tlast_o)
    else $error("pre-wait on a non-init strobe");

  // data strobes wait 0 after the high nibble, 45 after the low
  a_data_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o[33:19] == 15'd0 || m_tdata_o[33:19] == 15'd45)
    else $error("bad post-wait on data strobe");

endmodule

bind char_lcd_nibble_write_sequencer clcd_chk u_clcd_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);

### dv/testbench.sv
// Self-checking testbench for the character LCD 4-bit write sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam int LineChars  = 16;
  localparam int SpaceCap   = 19;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 8;
  localparam int OpLastCode = 7;
  localparam logic [7:0] Blank = 8'h20;
  localparam logic [7:0] GlyphRows [8] = '{
    8'h08, 8'h0C, 8'h0E, 8'h0F, 8'h0E, 8'h0C, 8'h08, 8'h00
  };

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [14:0] pre;
    logic [14:0] post;
    logic        last;
  } strobe_t;

  class strobe_scoreboard;
    logic [7:0] regs [8];
    strobe_t    expected_strobes [$];
    int         errors;

    function new();
      errors = 0;
      regs   = '{8'h80, 8'hC0, 8'h94, 8'hD4, 8'h0C, 8'h0C, 8'h02, 8'h01};
    endfunction

    function void set_reg(reg_idx_e idx, logic [7:0] val);
      regs[idx] = val;
    endfunction

    function int pending();
      return expected_strobes.size();
    endfunction

    function void push_nib(logic rs, logic [3:0] nib, logic [14:0] pre, logic [14:0] post);
      strobe_t s;
      s.rs   = rs;
      s.nib  = nib;
      s.pre  = pre;
      s.post = post;
      s.last = 1'b0;
      expected_strobes.push_back(s);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic [14:0] extra);
      logic [14:0] post;
      post = 15'd45 + extra;
      // home and clear commands need the slow settle time
      if (!rs && (b == regs[REG_HOME] || b == regs[REG_CLEAR])) post += 15'd2000;
      push_nib(rs, b[7:4], 15'd0, 15'd0);
      push_nib(rs, b[3:0], 15'd0, post);
    endfunction

    function void push_address(logic [2:0] row, logic [3:0] col);
      logic [7:0] addr;
      if (row < 3'd4) begin
        addr = regs[row[1:0]] + {4'd0, col};
        push_byte(1'b0, addr, 15'd0);
      end
    endfunction

    // predicts the strobes of one accepted request
    function void note_request(logic [2:0] op, logic [7:0] b, logic [3:0] col, logic [2:0] row);
      int      first;
      int      n;
      strobe_t s;
      first = expected_strobes.size();
      case (op)
        OP_CMD:  push_byte(1'b0, b, 15'd0);
        OP_DATA: push_byte(1'b1, b, 15'd0);
        OP_PUTXY: begin
          push_address(row, col);
          push_byte(1'b1, b, 15'd0);
        end
        OP_CLRLINE: begin
          push_address(row, 4'd0);
          n = (LineChars > SpaceCap) ? SpaceCap : LineChars;
          for (int i = 0; i < n; i++) push_byte(1'b1, Blank, 15'd0);
        end
        OP_INIT: begin
          push_nib(1'b0, 4'h3, 15'd20000, 15'd2000);
          push_nib(1'b0, 4'h3, 15'd5000, 15'd2000);
          push_nib(1'b0, 4'h3, 15'd0, 15'd2000);
          push_nib(1'b0, 4'h2, 15'd0, 15'd2000);
          push_byte(1'b0, 8'h20, 15'd0);
          push_byte(1'b0, 8'h28, 15'd0);
          push_byte(1'b0, 8'h14, 15'd0);
          push_byte(1'b0, 8'h0F, 15'd0);
          push_byte(1'b0, regs[REG_CLEAR], 15'd0);
          push_byte(1'b0, 8'h06, 15'd0);
          push_byte(1'b0, regs[REG_DISP_ON], 15'd20000);
          push_byte(1'b0, regs[REG_CUR_OFF], 15'd0);
          push_byte(1'b0, 8'h40, 15'd0);
          for (int i = 0; i < 8; i++) push_byte(1'b1, GlyphRows[i], 15'd0);
          push_byte(1'b0, regs[REG_HOME], 15'd0);
        end
        default: ;
      endcase
      if (expected_strobes.size() > first) begin
        s = expected_strobes.pop_back();
        s.last = 1'b1;
        expected_strobes.push_back(s);
      end
    endfunction

    function void check_strobe(logic rs, logic [3:0] nib, logic [14:0] pre, logic [14:0] post,
                               logic last);
      strobe_t e;
      if (expected_strobes.size() == 0) begin
        $error("strobe with nothing expected: rs %0d nibble %0h", rs, nib);
        errors++;
        return;
      end
      e = expected_strobes.pop_front();
      if (rs !== e.rs) begin
        $error("reg_select: expected %0d, got %0d", e.rs, rs);
        errors++;
      end
      if (nib !== e.nib) begin
        $error("nibble: expected %0h, got %0h", e.nib, nib);
        errors++;
      end
      if (pre !== e.pre) begin
        $error("pre_wait_us: expected %0d, got %0d", e.pre, pre);
        errors++;
      end
      if (post !== e.post) begin
        $error("post_wait_us: expected %0d, got %0d", e.post, post);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [15:0] s_tdata_i;   // byte_value[7:0], column[11:8], row[14:12]
  logic [2:0]  s_tuser_i;   // opcode[2:0]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [39:0] m_tdata_o;   // nibble[3:0], pre_wait_us[18:4], post_wait_us[33:19]
  logic        m_tuser_o;   // reg_select[0]
  logic        m_tlast_o;

  strobe_scoreboard sb;
  bit idle_en;
  int cycle_count;
  int strobes_seen;

  char_lcd_nibble_write_sequencer #(
    .LINE_CHARS(LineChars)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever @(posedge clk_i) cycle_count++;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  // receiver: random back-pressure while idling is on, plus one long hold-off to fill the block
  initial begin
    int  stall_left;
    bit  squeezed;
    stall_left   = 0;
    squeezed     = 1'b0;
    strobes_seen = 0;
    m_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid_o && m_tready_i) begin
        sb.check_strobe(m_tuser_o, m_tdata_o[3:0], m_tdata_o[18:4], m_tdata_o[33:19],
                        m_tlast_o);
        strobes_seen++;
      end
      if (!squeezed && strobes_seen >= 300) begin
        squeezed   = 1'b1;
        stall_left = 500;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else if (idle_en) begin
        m_tready_i <= ($urandom_range(0, 99) >= 38);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(logic [7:0] vals [8]);
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), vals[i]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // called at a clock edge; returns at the edge that took the transaction
  task automatic send_request(logic [2:0] op, logic [7:0] b, logic [3:0] col, logic [2:0] row);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 99) < 38) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {1'b0, row, col, b};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(op, b, col, row);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int         done;
    int         pick;
    logic [2:0] op;
    logic [7:0] b;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      op = OP_CMD;
      else if (pick < 50) op = OP_DATA;
      else if (pick < 80) op = OP_PUTXY;
      else if (pick < 89) op = OP_CLRLINE;
      else if (pick < 95) op = OP_INIT;
      else                op = 3'($urandom_range(int'(OP_INIT) + 1, OpLastCode));
      b = 8'($urandom_range(0, 255));
      // hit the slow commands often enough
      if (op == OP_CMD && $urandom_range(0, 4) == 0)
        b = $urandom_range(0, 1) ? sb.regs[REG_HOME] : sb.regs[REG_CLEAR];
      send_request(op, b, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      if (op <= OP_INIT) done++;
    end
  endtask

  task automatic random_regs(output logic [7:0] vals [8]);
    for (int i = 0; i < 8; i++) vals[i] = 8'($urandom_range(0, 255));
  endtask

  initial begin
    logic [7:0] vals [8];
    sb      = new();
    idle_en = 1'b1;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_LINE0;
    cfg_wdata_i <= 8'd0;
    s_tvalid_i  <= 1'b0;
    s_tdata_i   <= 16'd0;
    s_tuser_i   <= OP_CMD;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part on reset values
    send_request(OP_CMD, 8'h00, 4'd0, 3'd0);
    send_request(OP_CMD, 8'hFF, 4'd15, 3'd7);
    send_request(OP_CMD, 8'h02, 4'd0, 3'd0);
    send_request(OP_CMD, 8'h01, 4'd0, 3'd0);
    send_request(OP_DATA, 8'h00, 4'd0, 3'd0);
    send_request(OP_DATA, 8'hFF, 4'd15, 3'd7);
    send_request(OP_DATA, 8'h02, 4'd3, 3'd1);
    send_request(OP_PUTXY, 8'h41, 4'd0, 3'd0);
    send_request(OP_PUTXY, 8'h42, 4'd15, 3'd1);
    send_request(OP_PUTXY, 8'h43, 4'd7, 3'd2);
    send_request(OP_PUTXY, 8'hFF, 4'd15, 3'd3);
    send_request(OP_PUTXY, 8'h00, 4'd5, 3'd4);
    send_request(OP_PUTXY, 8'h7E, 4'd15, 3'd7);
    send_request(OP_CLRLINE, 8'h00, 4'd0, 3'd0);
    send_request(OP_CLRLINE, 8'hFF, 4'd15, 3'd3);
    send_request(OP_CLRLINE, 8'h55, 4'd9, 3'd6);
    send_request(OP_INIT, 8'hAA, 4'd10, 3'd5);
    send_request(3'(int'(OP_INIT) + 1), 8'hFF, 4'd15, 3'd7);
    send_request(3'(int'(OP_INIT) + 2), 8'h00, 4'd0, 3'd0);
    send_request(3'(OpLastCode), 8'h5A, 4'd6, 3'd2);
    send_request(OP_CMD, 8'h0C, 4'd0, 3'd0);
    run_random(90);
    drain();

    // all registers low: home, clear and display-on coincide
    vals = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    program_regs(vals);
    send_request(OP_INIT, 8'h00, 4'd0, 3'd0);
    send_request(OP_CMD, 8'h00, 4'd0, 3'd0);
    run_random(90);
    drain();

    // all registers high, address wraps; no idling on either side
    idle_en = 1'b0;
    vals = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    program_regs(vals);
    send_request(OP_PUTXY, 8'h30, 4'd15, 3'd3);
    send_request(OP_INIT, 8'h00, 4'd0, 3'd0);
    run_random(90);
    drain();
    idle_en = 1'b1;

    // random registers, display-on equal to clear
    random_regs(vals);
    vals[REG_DISP_ON] = vals[REG_CLEAR];
    program_regs(vals);
    send_request(OP_INIT, 8'h00, 4'd0, 3'd0);
    run_random(80);
    drain();

    // random registers
    random_regs(vals);
    program_regs(vals);
    run_random(80);
    drain();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
